// ----- hw/rtl/ccv_pkg.sv -----
// Package with the types, constants and byte conversion functions of the case style converter.
`default_nettype none

package ccv_pkg;

  // Style codes carried on the style field.
  localparam logic [2:0] STYLE_VERBATIM = 3'd0;
  localparam logic [2:0] STYLE_PASCAL   = 3'd1;
  localparam logic [2:0] STYLE_CAMEL    = 3'd2;
  localparam logic [2:0] STYLE_SNAKE    = 3'd3;
  localparam logic [2:0] STYLE_KEBAB    = 3'd4;
  localparam logic [2:0] STYLE_UPPER    = 3'd5;
  localparam logic [2:0] STYLE_LOWER    = 3'd6;

  // Character class codes.
  localparam logic [1:0] KIND_LOWER = 2'd0;
  localparam logic [1:0] KIND_UPPER = 2'd1;
  localparam logic [1:0] KIND_DIGIT = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // ASCII constants.
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HYPHEN     = 8'h2D;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // Most results that one input transaction can cause.
  localparam int unsigned MAX_RESULTS = 4;

  typedef struct packed {
    logic [7:0] char_in;
    logic [2:0] style;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       last_out;
  } out_item_t;

  // Results of one transaction, handed from the core to the output queue.
  typedef struct packed {
    out_item_t [MAX_RESULTS-1:0] item;
    logic [2:0]                  count;
  } result_list_t;

  // Outcome of converting one byte: up to two bytes and the updated word flags.
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       in_word;
    logic       word_seen;
  } conv_res_t;

  function automatic logic [1:0] kind_of(input logic [7:0] c);
    logic [1:0] k;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) k = KIND_LOWER;
    else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) k = KIND_UPPER;
    else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) k = KIND_DIGIT;
    else k = KIND_OTHER;
    return k;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;
  endfunction

  // Convert byte c, whose neighbors have kinds prev and next, under style st.
  function automatic conv_res_t conv_byte(input logic [7:0] c, input logic [1:0] prev,
                                          input logic [1:0] next, input logic [2:0] st,
                                          input logic iw, input logic ws);
    conv_res_t  r;
    logic [1:0] k;
    logic       bnd;
    logic       cap;
    logic [7:0] letter;
    r.n         = 2'd0;
    r.b0        = 8'd0;
    r.b1        = 8'd0;
    r.in_word   = iw;
    r.word_seen = ws;
    k           = kind_of(c);
    bnd         = 1'b0;
    cap         = 1'b0;
    letter      = 8'd0;
    case (st) inside
      STYLE_UPPER: begin
        r.n  = 2'd1;
        r.b0 = to_upper(c);
      end
      STYLE_LOWER: begin
        r.n  = 2'd1;
        r.b0 = to_lower(c);
      end
      STYLE_PASCAL, STYLE_CAMEL, STYLE_SNAKE, STYLE_KEBAB: begin
        if (k == KIND_OTHER) begin
          // Separators end the word and are dropped.
          r.in_word = 1'b0;
        end else begin
          bnd = iw && (k == KIND_UPPER) &&
                ((prev == KIND_LOWER) || (prev == KIND_UPPER && next == KIND_LOWER));
          if (bnd || !iw) begin
            cap    = (st == STYLE_PASCAL) || (st == STYLE_CAMEL && ws);
            letter = cap ? to_upper(c) : to_lower(c);
            if (ws && (st == STYLE_SNAKE || st == STYLE_KEBAB)) begin
              r.n  = 2'd2;
              r.b0 = (st == STYLE_SNAKE) ? CH_UNDERSCORE : CH_HYPHEN;
              r.b1 = letter;
            end else begin
              r.n  = 2'd1;
              r.b0 = letter;
            end
            r.word_seen = 1'b1;
            r.in_word   = 1'b1;
          end else begin
            r.n  = 2'd1;
            r.b0 = to_lower(c);
          end
        end
      end
      default: begin
        // Verbatim, and the unused code that behaves like it.
        r.n  = 2'd1;
        r.b0 = c;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ccv_in_stage.sv -----
// Input register that holds one accepted transaction until the core takes it.
`default_nettype none

module ccv_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire ccv_pkg::in_item_t in_data,
  output logic                  in_stall,
  input  wire logic             take,
  output logic                  item_valid,
  output ccv_pkg::in_item_t     item
);

  logic              valid_r;
  logic              valid_nxt;
  ccv_pkg::in_item_t item_r;
  logic              load;

  // The register can refill in the same cycle that the core takes its content.
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ccv_core.sv -----
// Conversion core: per-string state registers and the logic that turns one byte into results.
`default_nettype none

module ccv_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire ccv_pkg::in_item_t item,
  output ccv_pkg::result_list_t  list
);

  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [1:0] kind_before_r, kind_before_nxt;
  logic       in_word_r, in_word_nxt;
  logic       word_seen_r, word_seen_nxt;
  logic [2:0] style_r, style_nxt;

  logic [2:0]         st_eff;
  logic [1:0]         kind_new;
  logic [1:0]         prev_new;
  ccv_pkg::conv_res_t r1;
  ccv_pkg::conv_res_t r2;
  logic [2:0]         n1;
  logic [2:0]         n2;
  logic [2:0]         total;
  logic [2:0]         j;
  logic [7:0]         byte_sel;

  // The style is taken from the first byte of a string.
  assign st_eff   = held_valid_r ? style_r : item.style;
  assign kind_new = ccv_pkg::kind_of(item.char_in);
  assign prev_new = held_valid_r ? ccv_pkg::kind_of(held_char_r) : ccv_pkg::KIND_OTHER;

  // The held byte is converted with the new byte as lookahead.
  always_comb begin
    if (held_valid_r) begin
      r1 = ccv_pkg::conv_byte(held_char_r, kind_before_r, kind_new, st_eff,
                              in_word_r, word_seen_r);
    end else begin
      r1           = '0;
      r1.in_word   = in_word_r;
      r1.word_seen = word_seen_r;
    end
  end

  // On the last byte the new byte itself is converted with no lookahead.
  always_comb begin
    if (item.last_in) begin
      r2 = ccv_pkg::conv_byte(item.char_in, prev_new, ccv_pkg::KIND_OTHER, st_eff,
                              r1.in_word, r1.word_seen);
    end else begin
      r2 = '0;
    end
  end

  assign n1    = {1'b0, r1.n};
  assign n2    = {1'b0, r2.n};
  assign total = n1 + n2;

  // Pack the bytes of both conversions into one list and mark the last one.
  always_comb begin
    list.count = total;
    for (int i = 0; i < int'(ccv_pkg::MAX_RESULTS); i++) begin
      j = 3'(i) - n1;
      if (3'(i) < n1) begin
        byte_sel = (i == 0) ? r1.b0 : r1.b1;
      end else if (j == 3'd0) begin
        byte_sel = r2.b0;
      end else begin
        byte_sel = r2.b1;
      end
      list.item[i].char_out = byte_sel;
      list.item[i].has_char = 1'b1;
      list.item[i].last_out = item.last_in && (3'(i) == total - 3'd1);
    end
    if (item.last_in && total == 3'd0) begin
      // A closing byte that emits nothing still gives an empty end marker.
      list.count   = 3'd1;
      list.item[0] = '{char_out: 8'd0, has_char: 1'b0, last_out: 1'b1};
    end
  end

  // Next state: hold the new byte, or return to the idle state after the last byte.
  always_comb begin
    style_nxt = st_eff;
    if (item.last_in) begin
      held_char_nxt   = 8'd0;
      held_valid_nxt  = 1'b0;
      kind_before_nxt = ccv_pkg::KIND_OTHER;
      in_word_nxt     = 1'b0;
      word_seen_nxt   = 1'b0;
    end else begin
      held_char_nxt   = item.char_in;
      held_valid_nxt  = 1'b1;
      kind_before_nxt = prev_new;
      in_word_nxt     = r1.in_word;
      word_seen_nxt   = r1.word_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_char_r   <= 8'd0;
      held_valid_r  <= 1'b0;
      kind_before_r <= ccv_pkg::KIND_OTHER;
      in_word_r     <= 1'b0;
      word_seen_r   <= 1'b0;
      style_r       <= ccv_pkg::STYLE_VERBATIM;
    end else if (take) begin
      held_char_r   <= held_char_nxt;
      held_valid_r  <= held_valid_nxt;
      kind_before_r <= kind_before_nxt;
      in_word_r     <= in_word_nxt;
      word_seen_r   <= word_seen_nxt;
      style_r       <= style_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ccv_out_queue.sv -----
// Result register for the results of one transaction; one leaves per cycle unless stalled.
`default_nettype none

module ccv_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  take,
  input  wire ccv_pkg::result_list_t list,
  output logic                       q_ready,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output ccv_pkg::out_item_t         out_data
);

  ccv_pkg::out_item_t [ccv_pkg::MAX_RESULTS-1:0] list_r;
  logic [2:0] rem_r, rem_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       pop;

  assign out_valid = (rem_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  // A new list may load when the queue is empty or its final result leaves now.
  assign q_ready   = (rem_r == 3'd0) || (rem_r == 3'd1 && !out_stall);
  assign out_data  = list_r[idx_r];

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (take) begin
      rem_nxt = list.count;
      idx_nxt = 2'd0;
    end else if (pop) begin
      rem_nxt = rem_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
      idx_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      list_r <= list.item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/identifier_case_style_converter.sv -----
// Top level of the identifier case style converter.
//
// Usage: an identifier arrives one byte per input transaction on in_data
// (char_in, style, last_in) with in_valid/in_stall. The style is taken from
// the first byte of each string. Results leave on out_data (char_out,
// has_char, last_out) with out_valid/out_stall, one result per cycle while
// out_stall is low. Path: a byte is registered in the input register at
// acceptance and converted from there by the core, and its results load
// into the result register, which drives out_data; because a byte is
// converted only once its successor is known, output lags the input by one
// byte. The last byte flushes and always ends with a result marked last_out,
// possibly an empty marker with has_char low. Throughput: one input
// transaction per cycle as long as each byte yields at most one result and
// out_stall is low; a transaction with more than one result (at most four)
// holds the result register until the last of them leaves through the
// single output port. Reset (rst_n low, synchronous) empties both registers
// and starts a new string. When the receiver stalls, the current result
// holds and in_stall rises once the input register is full.
`default_nettype none

module identifier_case_style_converter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ccv_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ccv_pkg::out_item_t     out_data
);

  logic                  item_valid;
  ccv_pkg::in_item_t     item;
  logic                  q_ready;
  logic                  take;
  ccv_pkg::result_list_t list;

  // The core consumes the held transaction when the result register can take its results.
  assign take = item_valid && q_ready;

  ccv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ccv_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .item  (item),
    .list  (list)
  );

  ccv_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .list      (list),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ccv_checker.sv -----
// Port-level checker for the case style converter and its bind to the top level.
`default_nettype none

module ccv_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire ccv_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ccv_pkg::out_item_t out_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An empty result only ever closes a string.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_char |-> out_data.last_out)
    else $error("empty result without last_out");

  // An empty end marker carries a zero byte.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_char |-> out_data.char_out == 8'd0)
    else $error("empty result with nonzero char_out");

  // Reset leaves both sides empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind identifier_case_style_converter ccv_checker u_ccv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
